[src/lslf_pkg.sv]
// Shared types, widths, status codes and helpers for the line fit block.
// No dependencies; every other file refers to it by scoped names.
package lslf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_W     = 17;
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 47;
  localparam int XY_W        = 48;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam logic [COUNT_W-1:0] MAX_SAMPLES = 17'd65536;

  localparam logic [1:0] STATUS_NORMAL  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_CONST_X = 2'd2;
  localparam logic [1:0] STATUS_CONST_Y = 2'd3;

  typedef enum logic [1:0] {ALU_MUL, ALU_DIV, ALU_FRAC} alu_op_t;

  typedef enum logic [2:0] {PH_IDLE, PH_XX, PH_YY, PH_XY, PH_LAST} acc_phase_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ACC, ST_NXY, ST_SXSY, ST_NXX, ST_SXSX, ST_NYY, ST_SYSY,
    ST_CHECK, ST_MEANY, ST_SLOPE, ST_SYDX, ST_SXNUM, ST_NDX, ST_ICPT,
    ST_NUM2, ST_DXDY, ST_R2, ST_DONE
  } fit_state_t;

  // Saturate a sign and magnitude to a signed 32-bit value.
  function automatic logic [31:0] sat32(input logic neg, input logic [127:0] mag);
    logic [31:0] r;
    if (mag[127:32] != 96'd0) r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (neg) r = mag[31] ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    else r = mag[31] ? 32'h7FFF_FFFF : mag[31:0];
    return r;
  endfunction

  // Apply a sign to a 64-bit magnitude, wrapping.
  function automatic logic [63:0] sgn64(input logic neg, input logic [63:0] v);
    return neg ? (64'd0 - v) : v;
  endfunction

endpackage

[src/least_squares_line_fit_core.sv]
// Least-squares line fit: a sample transaction is accepted in idle and its products are
// summed in lslf_acc; the closing transaction runs the fit on the shared lslf_alu,
// a sequence of multiplies, divides and an r squared fraction.
// One transaction at a time; a finished result waits in the output register.
// Synchronous reset clears the sums, the sequencer and the output valid.
// Depends on lslf_pkg, lslf_acc and lslf_alu.
module least_squares_line_fit_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic signed [15:0]  sample_x,
  input  logic signed [15:0]  sample_y,
  input  logic                has_sample,
  input  logic                last_sample,
  output logic                fit_valid,
  input  logic                fit_ready,
  output logic signed [31:0]  slope,
  output logic signed [31:0]  intercept,
  output logic [16:0]         rsq,
  output logic [1:0]          fit_status,
  output logic [16:0]         sample_count
);

  lslf_pkg::fit_state_t state, state_next;
  logic issued, issued_next;
  logic last_r;
  logic acc_start, acc_clear, acc_busy;
  logic [lslf_pkg::COUNT_W-1:0] n;
  logic [lslf_pkg::SUM_W-1:0]   sx, sy;
  logic [lslf_pkg::SQ_W-1:0]    sxx, syy;
  logic [lslf_pkg::XY_W-1:0]    sxy;
  logic alu_start, alu_done;
  lslf_pkg::alu_op_t alu_op;
  logic [127:0] alu_a, alu_b, res;
  logic [63:0]  t1, num, dx, dy;
  logic [129:0] wide;
  logic [127:0] dd;
  logic [31:0]  slope_r, icpt_r;
  logic [16:0]  r2_r;
  logic [1:0]   status_r;
  logic [31:0]  sx_mag, sy_mag;
  logic [47:0]  sxy_mag;
  logic         sx_neg, sy_neg, num_neg;
  logic [63:0]  num_mag;
  logic [129:0] top_mag130;
  logic [129:0] sxnum130;
  logic         accept, out_load;

  lslf_acc u_acc (
    .clk(clk), .rst(rst), .start(acc_start), .clear(acc_clear),
    .x(sample_x), .y(sample_y), .busy(acc_busy), .count(n),
    .sum_x(sx), .sum_y(sy), .sum_xx(sxx), .sum_yy(syy), .sum_xy(sxy)
  );

  lslf_alu u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .op(alu_op),
    .opa(alu_a), .opb(alu_b), .done(alu_done), .result(res)
  );

  // Signs and magnitudes of the sums
  always_comb begin
    sx_neg     = sx[31];
    sy_neg     = sy[31];
    num_neg    = num[63];
    sx_mag     = sx_neg ? (32'd0 - sx) : sx;
    sy_mag     = sy_neg ? (32'd0 - sy) : sy;
    sxy_mag    = sxy[47] ? (48'd0 - sxy) : sxy;
    num_mag    = lslf_pkg::sgn64(num_neg, num);
    top_mag130 = wide[129] ? (130'd0 - wide) : wide;
    sxnum130   = (sx_neg ^ num_neg) ? (130'd0 - {2'b00, res}) : {2'b00, res};
  end

  assign sample_ready = (state == lslf_pkg::ST_IDLE) && !rst;
  assign accept       = sample_valid && sample_ready;
  assign acc_start    = accept && has_sample && (n < lslf_pkg::MAX_SAMPLES);
  assign out_load     = (state == lslf_pkg::ST_DONE) && (!fit_valid || fit_ready);
  assign acc_clear    = out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lslf_pkg::ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // Next state and shared-unit operand selection
  always_comb begin
    state_next  = state;
    issued_next = issued;
    alu_start   = 1'b0;
    alu_op      = lslf_pkg::ALU_MUL;
    alu_a       = '0;
    alu_b       = '0;
    unique case (state)
      lslf_pkg::ST_IDLE: if (accept) state_next = lslf_pkg::ST_ACC;
      lslf_pkg::ST_ACC: begin
        if (!acc_busy) state_next = last_r ? lslf_pkg::ST_NXY : lslf_pkg::ST_IDLE;
      end
      lslf_pkg::ST_CHECK: begin
        if (n == '0) state_next = lslf_pkg::ST_DONE;
        else if (dx == 64'd0) state_next = lslf_pkg::ST_MEANY;
        else state_next = lslf_pkg::ST_SLOPE;
      end
      lslf_pkg::ST_DONE: if (out_load) state_next = lslf_pkg::ST_IDLE;
      default: begin
        unique case (state)
          lslf_pkg::ST_NXY:   begin alu_a = {111'd0, n}; alu_b = {80'd0, sxy_mag}; end
          lslf_pkg::ST_SXSY:  begin alu_a = {96'd0, sx_mag}; alu_b = {96'd0, sy_mag}; end
          lslf_pkg::ST_NXX:   begin alu_a = {111'd0, n}; alu_b = {81'd0, sxx}; end
          lslf_pkg::ST_SXSX:  begin alu_a = {96'd0, sx_mag}; alu_b = {96'd0, sx_mag}; end
          lslf_pkg::ST_NYY:   begin alu_a = {111'd0, n}; alu_b = {81'd0, syy}; end
          lslf_pkg::ST_SYSY:  begin alu_a = {96'd0, sy_mag}; alu_b = {96'd0, sy_mag}; end
          lslf_pkg::ST_MEANY: begin
            alu_op = lslf_pkg::ALU_DIV;
            alu_a  = {88'd0, sy_mag, 8'd0};
            alu_b  = {111'd0, n};
          end
          lslf_pkg::ST_SLOPE: begin
            alu_op = lslf_pkg::ALU_DIV;
            alu_a  = {48'd0, num_mag, 16'd0};
            alu_b  = {64'd0, dx};
          end
          lslf_pkg::ST_SYDX:  begin alu_a = {96'd0, sy_mag}; alu_b = {64'd0, dx}; end
          lslf_pkg::ST_SXNUM: begin alu_a = {96'd0, sx_mag}; alu_b = {64'd0, num_mag}; end
          lslf_pkg::ST_NDX:   begin alu_a = {111'd0, n}; alu_b = {64'd0, dx}; end
          lslf_pkg::ST_ICPT: begin
            alu_op = lslf_pkg::ALU_DIV;
            alu_a  = {top_mag130[119:0], 8'd0};
            alu_b  = dd;
          end
          lslf_pkg::ST_NUM2:  begin alu_a = {64'd0, num_mag}; alu_b = {64'd0, num_mag}; end
          lslf_pkg::ST_DXDY:  begin alu_a = {64'd0, dx}; alu_b = {64'd0, dy}; end
          lslf_pkg::ST_R2: begin
            alu_op = lslf_pkg::ALU_FRAC;
            alu_a  = wide[127:0];
            alu_b  = dd;
          end
          default: alu_a = '0;
        endcase
        if (!issued) begin
          alu_start   = 1'b1;
          issued_next = 1'b1;
        end else if (alu_done) begin
          issued_next = 1'b0;
          unique case (state)
            lslf_pkg::ST_NXY:   state_next = lslf_pkg::ST_SXSY;
            lslf_pkg::ST_SXSY:  state_next = lslf_pkg::ST_NXX;
            lslf_pkg::ST_NXX:   state_next = lslf_pkg::ST_SXSX;
            lslf_pkg::ST_SXSX:  state_next = lslf_pkg::ST_NYY;
            lslf_pkg::ST_NYY:   state_next = lslf_pkg::ST_SYSY;
            lslf_pkg::ST_SYSY:  state_next = lslf_pkg::ST_CHECK;
            lslf_pkg::ST_MEANY: state_next = lslf_pkg::ST_DONE;
            lslf_pkg::ST_SLOPE: state_next = lslf_pkg::ST_SYDX;
            lslf_pkg::ST_SYDX:  state_next = lslf_pkg::ST_SXNUM;
            lslf_pkg::ST_SXNUM: state_next = lslf_pkg::ST_NDX;
            lslf_pkg::ST_NDX:   state_next = lslf_pkg::ST_ICPT;
            lslf_pkg::ST_ICPT:
              state_next = (dy == 64'd0) ? lslf_pkg::ST_DONE : lslf_pkg::ST_NUM2;
            lslf_pkg::ST_NUM2:  state_next = lslf_pkg::ST_DXDY;
            lslf_pkg::ST_DXDY:  state_next = lslf_pkg::ST_R2;
            default:            state_next = lslf_pkg::ST_DONE;
          endcase
        end
      end
    endcase
  end

  // Capture the closing flag and each finished partial result
  always_ff @(posedge clk) begin
    if (accept) last_r <= last_sample;
    if (state == lslf_pkg::ST_CHECK) begin
      slope_r <= '0;
      icpt_r  <= '0;
      r2_r    <= '0;
      if (n == '0) status_r <= lslf_pkg::STATUS_EMPTY;
      else if (dx == 64'd0) status_r <= lslf_pkg::STATUS_CONST_X;
      else if (dy == 64'd0) status_r <= lslf_pkg::STATUS_CONST_Y;
      else status_r <= lslf_pkg::STATUS_NORMAL;
    end
    if (alu_done && issued) begin
      case (state)
        lslf_pkg::ST_NXY:   t1 <= lslf_pkg::sgn64(sxy[47], res[63:0]);
        lslf_pkg::ST_SXSY:  num <= t1 - lslf_pkg::sgn64(sx_neg ^ sy_neg, res[63:0]);
        lslf_pkg::ST_NXX:   t1 <= res[63:0];
        lslf_pkg::ST_SXSX:  dx <= t1 - res[63:0];
        lslf_pkg::ST_NYY:   t1 <= res[63:0];
        lslf_pkg::ST_SYSY:  dy <= t1 - res[63:0];
        lslf_pkg::ST_MEANY: icpt_r <= lslf_pkg::sat32(sy_neg, res);
        lslf_pkg::ST_SLOPE: slope_r <= lslf_pkg::sat32(num_neg, res);
        lslf_pkg::ST_SYDX:  wide <= sy_neg ? (130'd0 - {2'b00, res}) : {2'b00, res};
        lslf_pkg::ST_SXNUM: wide <= wide - sxnum130;
        lslf_pkg::ST_NDX:   dd <= res;
        lslf_pkg::ST_ICPT:  icpt_r <= lslf_pkg::sat32(wide[129], res);
        lslf_pkg::ST_NUM2:  wide <= {2'b00, res};
        lslf_pkg::ST_DXDY:  dd <= res;
        lslf_pkg::ST_R2:    r2_r <= res[16:0];
        default:            t1 <= t1;
      endcase
    end
  end

  // Hold the result transaction until it is taken
  always_ff @(posedge clk) begin
    if (rst) fit_valid <= 1'b0;
    else if (out_load) fit_valid <= 1'b1;
    else if (fit_ready) fit_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slope        <= slope_r;
      intercept    <= icpt_r;
      rsq          <= r2_r;
      fit_status   <= status_r;
      sample_count <= n;
    end
  end

endmodule

[src/lslf_acc.sv]
// Sample accumulator: count and exact sums, one shared 16x16 multiplier.
// Depends on lslf_pkg.
module lslf_acc (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  clear,
  input  logic signed [lslf_pkg::SAMPLE_BITS-1:0] x,
  input  logic signed [lslf_pkg::SAMPLE_BITS-1:0] y,
  output logic                                  busy,
  output logic [lslf_pkg::COUNT_W-1:0]          count,
  output logic [lslf_pkg::SUM_W-1:0]            sum_x,
  output logic [lslf_pkg::SUM_W-1:0]            sum_y,
  output logic [lslf_pkg::SQ_W-1:0]             sum_xx,
  output logic [lslf_pkg::SQ_W-1:0]             sum_yy,
  output logic [lslf_pkg::XY_W-1:0]             sum_xy
);

  lslf_pkg::acc_phase_t phase;
  logic signed [lslf_pkg::SAMPLE_BITS-1:0] xr, yr;
  logic signed [lslf_pkg::PROD_W-1:0] prod;
  logic signed [lslf_pkg::SAMPLE_BITS-1:0] ma, mb;

  assign busy = (phase != lslf_pkg::PH_IDLE);

  // Select multiplier operands by phase
  always_comb begin
    ma = xr;
    mb = xr;
    case (phase)
      lslf_pkg::PH_YY: begin ma = yr; mb = yr; end
      lslf_pkg::PH_XY: begin ma = xr; mb = yr; end
      default: begin ma = xr; mb = xr; end
    endcase
  end

  // Sequence the three products
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lslf_pkg::PH_IDLE;
    end else begin
      unique case (phase)
        lslf_pkg::PH_IDLE: if (start) phase <= lslf_pkg::PH_XX;
        lslf_pkg::PH_XX:   phase <= lslf_pkg::PH_YY;
        lslf_pkg::PH_YY:   phase <= lslf_pkg::PH_XY;
        lslf_pkg::PH_XY:   phase <= lslf_pkg::PH_LAST;
        lslf_pkg::PH_LAST: phase <= lslf_pkg::PH_IDLE;
        default:           phase <= lslf_pkg::PH_IDLE;
      endcase
    end
  end

  // Register product, then add it into its sum
  always_ff @(posedge clk) begin
    prod <= {{lslf_pkg::SAMPLE_BITS{ma[lslf_pkg::SAMPLE_BITS-1]}}, ma}
          * {{lslf_pkg::SAMPLE_BITS{mb[lslf_pkg::SAMPLE_BITS-1]}}, mb};
    if (start) begin
      xr <= x;
      yr <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count  <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_yy <= '0;
      sum_xy <= '0;
    end else begin
      if (start) begin
        count <= count + 17'd1;
        sum_x <= sum_x + {{(lslf_pkg::SUM_W-lslf_pkg::SAMPLE_BITS){x[lslf_pkg::SAMPLE_BITS-1]}}, x};
        sum_y <= sum_y + {{(lslf_pkg::SUM_W-lslf_pkg::SAMPLE_BITS){y[lslf_pkg::SAMPLE_BITS-1]}}, y};
      end
      if (phase == lslf_pkg::PH_YY)
        sum_xx <= sum_xx + {{(lslf_pkg::SQ_W-lslf_pkg::PROD_W){1'b0}}, prod};
      if (phase == lslf_pkg::PH_XY)
        sum_yy <= sum_yy + {{(lslf_pkg::SQ_W-lslf_pkg::PROD_W){1'b0}}, prod};
      if (phase == lslf_pkg::PH_LAST)
        sum_xy <= sum_xy + {{(lslf_pkg::XY_W-lslf_pkg::PROD_W){prod[lslf_pkg::PROD_W-1]}}, prod};
    end
  end

endmodule

[src/lslf_alu.sv]
// Shared iterative unit: 64x64 shift-add multiply, rounded 128-bit divide,
// and Q1.16 fraction, one bit per cycle on one 130-bit adder. Uses lslf_pkg.
module lslf_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  lslf_pkg::alu_op_t     op,
  input  logic [127:0]          opa,
  input  logic [127:0]          opb,
  output logic                  done,
  output logic [127:0]          result
);

  logic                busy, fin;
  lslf_pkg::alu_op_t   op_r;
  logic [6:0]          cnt;
  logic [6:0]          cnt_last;
  logic [128:0]        acc;
  logic [127:0]        xr, yr;
  logic                sub;
  logic [128:0]        rem_sh, lhs, opnd;
  logic [129:0]        sum;
  logic                ge;
  logic                rnd;
  logic [17:0]         fq;

  // Add or subtract on the shared adder
  always_comb begin
    sub    = (op_r != lslf_pkg::ALU_MUL);
    rem_sh = {acc[127:0], xr[127]};
    lhs    = sub ? rem_sh : acc;
    opnd   = sub ? {1'b0, yr} : {1'b0, xr};
    sum    = {1'b0, lhs} + (sub ? ~{1'b0, opnd} : {1'b0, opnd}) + {129'd0, sub};
    ge     = ~sum[129];
    case (op_r)
      lslf_pkg::ALU_MUL: cnt_last = 7'd63;
      lslf_pkg::ALU_DIV: cnt_last = 7'd127;
      default:           cnt_last = 7'd16;
    endcase
  end

  // Round the finished quotient
  always_comb begin
    rnd = ({acc, 1'b0} >= {2'b00, yr});
    fq  = ({1'b0, xr[16:0]} + 18'd1) >> 1;
    case (op_r)
      lslf_pkg::ALU_MUL: result = acc[127:0];
      lslf_pkg::ALU_DIV: result = xr + {127'd0, rnd};
      default:           result = (fq > 18'd65536) ? 128'd65536 : {110'd0, fq};
    endcase
  end

  assign done = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= busy && (cnt == cnt_last);
      if (start) busy <= 1'b1;
      else if (busy && cnt == cnt_last) busy <= 1'b0;
    end
  end

  // Load operands, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= op;
      cnt  <= '0;
      case (op)
        lslf_pkg::ALU_MUL: begin
          acc <= '0; xr <= opa; yr <= {64'd0, opb[63:0]};
        end
        lslf_pkg::ALU_DIV: begin
          acc <= '0; xr <= opa; yr <= opb;
        end
        default: begin
          acc <= {1'b0, opa}; xr <= '0; yr <= opb;
        end
      endcase
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (op_r == lslf_pkg::ALU_MUL) begin
        if (yr[0]) acc <= sum[128:0];
        xr <= xr << 1;
        yr <= yr >> 1;
      end else begin
        acc <= ge ? sum[128:0] : rem_sh;
        xr  <= {xr[126:0], ge};
      end
    end
  end

endmodule

[src/lslf_checker.sv]
// Port-level checks for the line fit core, bound to the top level.
// Depends on lslf_pkg for status codes.
module lslf_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic               fit_valid,
  input logic               fit_ready,
  input logic signed [31:0] slope,
  input logic signed [31:0] intercept,
  input logic [16:0]        rsq,
  input logic [1:0]         fit_status,
  input logic [16:0]        sample_count
);

  // Result stays offered until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    fit_valid && !fit_ready |=> fit_valid) else $error("result dropped");

  // Each accepted transaction keeps the block busy for a while
  a_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready) else $error("ready after accept");

  a_r2: assert property (@(posedge clk) disable iff (rst)
    fit_valid |-> rsq <= 17'd65536) else $error("r squared above one");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_status == lslf_pkg::STATUS_EMPTY |->
      slope == 32'sd0 && intercept == 32'sd0 && rsq == 17'd0 && sample_count == 17'd0)
    else $error("empty run with nonzero result");

  a_constx: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_status == lslf_pkg::STATUS_CONST_X |->
      slope == 32'sd0 && rsq == 17'd0 && sample_count != 17'd0)
    else $error("constant x run with slope or r squared");

endmodule

bind least_squares_line_fit_core lslf_checker u_lslf_checker (.*);
